// ===== design/u8sd_pkg.sv =====
package u8sd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned CpW      = 21;
	localparam int unsigned PartialW = 15;
	localparam int unsigned PayloadW = 6;

	localparam logic [CpW-1:0]   ReplacementChar = 21'h00FFFD;

	// Byte class masks and patterns
	localparam logic [ByteW-1:0] AsciiMask    = 8'h80;
	localparam logic [ByteW-1:0] Lead2Mask    = 8'hE0;
	localparam logic [ByteW-1:0] Lead2Pattern = 8'hC0;
	localparam logic [ByteW-1:0] Lead3Mask    = 8'hF0;
	localparam logic [ByteW-1:0] Lead3Pattern = 8'hE0;
	localparam logic [ByteW-1:0] Lead4Mask    = 8'hF8;
	localparam logic [ByteW-1:0] Lead4Pattern = 8'hF0;
	localparam logic [ByteW-1:0] ContMask     = 8'hC0;
	localparam logic [ByteW-1:0] ContPattern  = 8'h80;
	localparam logic [ByteW-1:0] Lead2Bits    = 8'h1F;
	localparam logic [ByteW-1:0] Lead3Bits    = 8'h0F;
	localparam logic [ByteW-1:0] Lead4Bits    = 8'h07;

	// Decoder state carried between words
	typedef struct packed {
		logic [1:0]          pending;
		logic [PartialW-1:0] partial;
		logic                err;
	} u8sd_state_t;

	// One decoded result
	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           replaced;
		logic           final_result;
		logic           string_ok;
	} u8sd_result_t;

endpackage

// ===== design/u8sd_step.sv =====
module u8sd_step (
	input  u8sd_pkg::u8sd_state_t  st,
	input  logic [7:0]             byte_value,
	input  logic                   end_of_string,
	output u8sd_pkg::u8sd_state_t  st_next,
	output logic                   emit,
	output u8sd_pkg::u8sd_result_t res
);
	import u8sd_pkg::*;

	logic [CpW-1:0] acc;
	logic [CpW-1:0] cp;
	logic           bad;

	// Shift the gathered payload up and append the continuation bits
	assign acc = {st.partial, byte_value[PayloadW-1:0]};

	// Classify the word and advance the sequence
	always_comb begin
		st_next = st;
		emit    = 1'b0;
		bad     = 1'b0;
		cp      = '0;
		if (st.pending == 2'd0) begin
			if ((byte_value & AsciiMask) == '0) begin
				cp   = {{(CpW-ByteW){1'b0}}, byte_value};
				emit = 1'b1;
			end else if ((byte_value & Lead2Mask) == Lead2Pattern) begin
				st_next.partial = {{(PartialW-ByteW){1'b0}}, byte_value & Lead2Bits};
				st_next.pending = 2'd1;
			end else if ((byte_value & Lead3Mask) == Lead3Pattern) begin
				st_next.partial = {{(PartialW-ByteW){1'b0}}, byte_value & Lead3Bits};
				st_next.pending = 2'd2;
			end else if ((byte_value & Lead4Mask) == Lead4Pattern) begin
				st_next.partial = {{(PartialW-ByteW){1'b0}}, byte_value & Lead4Bits};
				st_next.pending = 2'd3;
			end else begin
				bad = 1'b1;
			end
		end else if ((byte_value & ContMask) != ContPattern) begin
			// Swallow the bad continuation and expect a lead again
			bad             = 1'b1;
			st_next.pending = 2'd0;
			st_next.partial = '0;
		end else begin
			st_next.pending = st.pending - 2'd1;
			if (st.pending == 2'd1) begin
				cp              = acc;
				st_next.partial = '0;
				emit            = 1'b1;
			end else begin
				st_next.partial = acc[PartialW-1:0];
			end
		end

		// A sequence still open on the last word is truncated
		if (!emit && !bad && end_of_string) begin
			bad = 1'b1;
		end

		if (bad) begin
			cp          = ReplacementChar;
			st_next.err = 1'b1;
			emit        = 1'b1;
		end

		res.code_point   = cp;
		res.replaced     = bad;
		res.final_result = end_of_string;
		res.string_ok    = end_of_string && !st_next.err;

		// Start the next string from a clean state
		if (end_of_string) begin
			st_next = '0;
		end
	end

endmodule

// ===== design/utf8_stream_decoder_core.sv =====
// Channel  Direction  Handshake             Word
// in       to block   in_valid / in_ready   byte_value, end_of_string
// out      from block out_valid / out_ready code_point, replaced, final_result, string_ok
//
// One byte is taken per cycle while in_ready is high. A byte that ends a character or a string,
// or is bad, is decoded from the input stage into the result register, which drives the outputs.
// Reset (arst_n low) empties both stages and returns the decoder to expecting a lead.
// A stalled result holds the result register; the input stage then holds its byte
// and in_ready drops only once both stages are full.
module utf8_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        replaced,
	output logic        final_result,
	output logic        string_ok
);
	import u8sd_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eos_s1;
	u8sd_state_t  state_q;
	u8sd_state_t  state_next;
	logic         emit;
	u8sd_result_t res;
	u8sd_result_t res_s2;
	logic         valid_s2;
	logic         out_free;
	logic         advance;

	// Move stage 1 forward whenever the result register can take its word
	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	u8sd_step u_step (
		.st            (state_q),
		.byte_value    (byte_s1),
		.end_of_string (eos_s1),
		.st_next       (state_next),
		.emit          (emit),
		.res           (res)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			eos_s1  <= end_of_string;
		end
	end

	// Decoder state advances once per consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign code_point   = res_s2.code_point;
	assign replaced     = res_s2.replaced;
	assign final_result = res_s2.final_result;
	assign string_ok    = res_s2.string_ok;

`ifndef ASSERT_OFF
	// A replacement always carries U+FFFD
	a_repl_cp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.replaced |-> res_s2.code_point == ReplacementChar)
		else $error("replacement result without U+FFFD");

	// string_ok only on a final, clean result
	a_ok_final: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.string_ok |-> res_s2.final_result && !res_s2.replaced)
		else $error("string_ok on a non-final or replaced result");

	// The last byte always yields a result
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |-> emit)
		else $error("last byte produced no result");

	// After the last byte the decoder is back at its reset state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |=> state_q == '0)
		else $error("decoder state not cleared after last byte");

	// No partial payload bits are left over while the decoder expects a lead
	a_partial_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending == 2'd0 |-> state_q.partial == '0)
		else $error("partial bits left over while expecting a lead");
`endif

endmodule

// ===== dv/utf8_stream_decoder_core_tb.sv =====
module utf8_stream_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8sd_pkg::*;

	localparam int unsigned CycleLimit  = 300000;
	localparam int unsigned RandomBytes = 2000;
	localparam int unsigned BusyPct     = 12;
	localparam int unsigned TailCycles  = 8;

	// One directed word; res is only used when its expected result is typed in
	typedef struct packed {
		logic [ByteW-1:0] b;
		logic             last;
		logic             typed;
		u8sd_result_t     res;
	} stim_row_t;

	localparam u8sd_result_t NoRes = '0;
	localparam int unsigned NumDirected = 26;
	localparam stim_row_t Directed [NumDirected] = '{
		// plain ASCII at both ends of its range
		'{8'h00, 1'b0, 1'b1, '{21'h000000, 1'b0, 1'b0, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{21'h00007F, 1'b0, 1'b0, 1'b0}},
		// two, three and four byte sequences
		'{8'hC2, 1'b0, 1'b0, NoRes},
		'{8'hA9, 1'b0, 1'b0, NoRes},
		'{8'hE2, 1'b0, 1'b0, NoRes},
		'{8'h82, 1'b0, 1'b0, NoRes},
		'{8'hAC, 1'b0, 1'b0, NoRes},
		'{8'hF0, 1'b0, 1'b0, NoRes},
		'{8'h9F, 1'b0, 1'b0, NoRes},
		'{8'h98, 1'b0, 1'b0, NoRes},
		'{8'h80, 1'b0, 1'b0, NoRes},
		// largest code point the format can carry
		'{8'hF7, 1'b0, 1'b0, NoRes},
		'{8'hBF, 1'b0, 1'b0, NoRes},
		'{8'hBF, 1'b0, 1'b0, NoRes},
		'{8'hBF, 1'b0, 1'b1, '{21'h1FFFFF, 1'b0, 1'b0, 1'b0}},
		// stray continuation and invalid leads, the last one ends the string
		'{8'h80, 1'b0, 1'b1, '{ReplacementChar, 1'b1, 1'b0, 1'b0}},
		'{8'hF8, 1'b0, 1'b1, '{ReplacementChar, 1'b1, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, '{ReplacementChar, 1'b1, 1'b1, 1'b0}},
		// clean one-word string after the error flag was cleared
		'{8'h41, 1'b1, 1'b1, '{21'h000041, 1'b0, 1'b1, 1'b1}},
		// bad continuation is swallowed, then a lead cut off by the end mark
		'{8'hE0, 1'b0, 1'b0, NoRes},
		'{8'h41, 1'b0, 1'b1, '{ReplacementChar, 1'b1, 1'b0, 1'b0}},
		'{8'hC3, 1'b1, 1'b1, '{ReplacementChar, 1'b1, 1'b1, 1'b0}},
		// good continuation that still leaves bytes pending at the end mark
		'{8'hF0, 1'b0, 1'b0, NoRes},
		'{8'h90, 1'b1, 1'b1, '{ReplacementChar, 1'b1, 1'b1, 1'b0}},
		// overlong form is accepted as is
		'{8'hC0, 1'b0, 1'b0, NoRes},
		'{8'h80, 1'b1, 1'b0, NoRes}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value    = '0;
	logic        end_of_string = 1'b0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [20:0] code_point;
	logic        replaced;
	logic        final_result;
	logic        string_ok;

	// decoder state mirrored by the predictor
	logic [1:0]          dec_pending = '0;
	logic [PartialW-1:0] dec_partial = '0;
	logic                dec_err     = 1'b0;

	u8sd_result_t pending_results[$];
	int unsigned  mismatches = 0;
	int unsigned  cycles     = 0;
	int unsigned  idle_pct   = BusyPct;

	utf8_stream_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_point   (code_point),
		.replaced     (replaced),
		.final_result (final_result),
		.string_ok    (string_ok)
	);

	always #4 clk = ~clk;

	// Advance the decoder by one byte; returns 1 when the byte yields a code point
	function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic last,
			output u8sd_result_t res);
		logic [CpW-1:0] cp;
		logic [CpW-1:0] acc;
		bit             emit;
		bit             bad;
		cp   = '0;
		emit = 1'b0;
		bad  = 1'b0;
		if (dec_pending == 2'd0) begin
			if ((b & AsciiMask) == '0) begin
				cp   = {{(CpW-ByteW){1'b0}}, b};
				emit = 1'b1;
			end else if ((b & Lead2Mask) == Lead2Pattern) begin
				dec_partial = {{(PartialW-ByteW){1'b0}}, b & Lead2Bits};
				dec_pending = 2'd1;
			end else if ((b & Lead3Mask) == Lead3Pattern) begin
				dec_partial = {{(PartialW-ByteW){1'b0}}, b & Lead3Bits};
				dec_pending = 2'd2;
			end else if ((b & Lead4Mask) == Lead4Pattern) begin
				dec_partial = {{(PartialW-ByteW){1'b0}}, b & Lead4Bits};
				dec_pending = 2'd3;
			end else begin
				bad = 1'b1;
			end
		end else if ((b & ContMask) != ContPattern) begin
			// drop the broken sequence and the offending byte
			bad         = 1'b1;
			dec_pending = 2'd0;
			dec_partial = '0;
		end else begin
			acc         = {dec_partial, b[PayloadW-1:0]};
			dec_pending = dec_pending - 2'd1;
			if (dec_pending == 2'd0) begin
				cp          = acc;
				dec_partial = '0;
				emit        = 1'b1;
			end else begin
				dec_partial = acc[PartialW-1:0];
			end
		end
		// end mark in the middle of a sequence
		if (!emit && !bad && last)
			bad = 1'b1;
		if (bad) begin
			cp      = ReplacementChar;
			dec_err = 1'b1;
			emit    = 1'b1;
		end
		res.code_point   = cp;
		res.replaced     = bad;
		res.final_result = last;
		res.string_ok    = last && !dec_err;
		if (last) begin
			dec_pending = '0;
			dec_partial = '0;
			dec_err     = 1'b0;
		end
		return emit;
	endfunction

	// Offer one word, hold it until taken, then log what it should produce
	task automatic send_word(input logic [ByteW-1:0] b, input logic last,
			input logic typed, input u8sd_result_t typed_res);
		u8sd_result_t res;
		bit           has;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		byte_value    <= b;
		end_of_string <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		has = decode_byte(b, last, res);
		if (typed)
			pending_results.push_back(typed_res);
		else if (has)
			pending_results.push_back(res);
	endtask

	// Hold the sender until every expected code point has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ByteW-1:0] cont_byte();
		return ContPattern | ByteW'($urandom_range(63));
	endfunction

	// Build one string: mostly well-formed characters, some noise and broken ones
	task automatic send_random_string(inout int unsigned sent);
		logic [ByteW-1:0] bytes[$];
		int unsigned      nchars;
		int unsigned      len;
		int unsigned      kind;
		nchars = $urandom_range(1, 12);
		repeat (nchars) begin
			kind = $urandom_range(99);
			len  = $urandom_range(1, 4);
			if (kind < 85) begin
				case (len)
					1: bytes.push_back(ByteW'($urandom_range(127)));
					2: bytes.push_back(Lead2Pattern | ByteW'($urandom_range(31)));
					3: bytes.push_back(Lead3Pattern | ByteW'($urandom_range(15)));
					default: bytes.push_back(Lead4Pattern | ByteW'($urandom_range(7)));
				endcase
				repeat (len - 1)
					bytes.push_back(cont_byte());
			end else if (kind < 92) begin
				bytes.push_back(ByteW'($urandom_range(255)));
			end else begin
				// multi-byte lead with too few continuations, maybe a random byte after
				len = $urandom_range(2, 4);
				case (len)
					2: bytes.push_back(Lead2Pattern | ByteW'($urandom_range(31)));
					3: bytes.push_back(Lead3Pattern | ByteW'($urandom_range(15)));
					default: bytes.push_back(Lead4Pattern | ByteW'($urandom_range(7)));
				endcase
				repeat ($urandom_range(0, len - 2))
					bytes.push_back(cont_byte());
				if ($urandom_range(1))
					bytes.push_back(ByteW'($urandom_range(255)));
			end
		end
		foreach (bytes[i]) begin
			idle_pct = (sent >= 800 && sent < 1200) ? 0 : BusyPct;
			send_word(bytes[i], i == bytes.size() - 1, 1'b0, NoRes);
			sent++;
		end
	endtask

	// Compare each taken code point with the oldest expected one
	always @(posedge clk) begin
		u8sd_result_t exp_res;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: code_point=%h replaced=%b final_result=%b string_ok=%b",
					code_point, replaced, final_result, string_ok);
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (code_point !== exp_res.code_point) begin
					$error("code_point: expected %h, got %h", exp_res.code_point, code_point);
					mismatches++;
				end
				if (replaced !== exp_res.replaced) begin
					$error("replaced: expected %b, got %b", exp_res.replaced, replaced);
					mismatches++;
				end
				if (final_result !== exp_res.final_result) begin
					$error("final_result: expected %b, got %b", exp_res.final_result,
						final_result);
					mismatches++;
				end
				if (string_ok !== exp_res.string_ok) begin
					$error("string_ok: expected %b, got %b", exp_res.string_ok, string_ok);
					mismatches++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		bit          mid_drained;
		sent        = 0;
		mid_drained = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		foreach (Directed[i])
			send_word(Directed[i].b, Directed[i].last, Directed[i].typed, Directed[i].res);
		drain();

		// random strings, with one full drain partway through
		while (sent < RandomBytes) begin
			send_random_string(sent);
			if (sent >= 1000 && !mid_drained) begin
				drain();
				mid_drained = 1'b1;
			end
		end

		drain();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
design/u8sd_pkg.sv
design/u8sd_step.sv
design/utf8_stream_decoder_core.sv
dv/utf8_stream_decoder_core_tb.sv
